@@ rtl/drp_pkg.sv @@
package drp_pkg;

   // Field widths.
   localparam int PIX_W   = 12;
   localparam int CFG_W   = 16;
   localparam int PROD_W  = 32;
   localparam int MD_W    = 28;
   localparam int CMP_W   = 36;
   localparam int REM_W   = 12;
   localparam int COORD_W = 34;
   localparam int MUL_W   = 50;
   localparam int ACC_W   = 53;
   localparam int PNT_W   = 32;
   localparam int DIV_STG = 8;
   localparam int DIV_BPS = 4;

   // Configuration port.
   localparam int ADDR_W  = 6;
   localparam int DATA_W  = 64;

   // Register indexes.
   localparam logic [2:0] REG_FOCAL   = 3'd0;
   localparam logic [2:0] REG_BASE    = 3'd1;
   localparam logic [2:0] REG_PU      = 3'd2;
   localparam logic [2:0] REG_PV      = 3'd3;
   localparam logic [2:0] REG_MAXD    = 3'd4;
   localparam logic [2:0] REG_ROW_X   = 3'd5;
   localparam logic [2:0] REG_ROW_Y   = 3'd6;
   localparam logic [2:0] REG_ROW_Z   = 3'd7;

   // Reset values.
   localparam logic [15:0] MAXD_RST  = 16'd5120;
   localparam logic [63:0] ROW_X_RST = 64'h0000_0000_0000_4000;
   localparam logic [63:0] ROW_Y_RST = 64'h0000_0000_4000_0000;
   localparam logic [63:0] ROW_Z_RST = 64'h0000_4000_0000_0000;

   // Rounding bias for the Q30 to Q16 step.
   localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(8192);
   localparam logic signed [PNT_W-1:0] PNT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [PNT_W-1:0] PNT_MIN = 32'sh8000_0000;

   typedef enum logic [1:0] {
      ST_VALID   = 2'd0,
      ST_NO_DISP = 2'd1,
      ST_RANGE   = 2'd2
   } status_type;

   // One running division: partial remainder and dividend/quotient register.
   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [PROD_W-1:0] dvd;
   } part_type;

   typedef struct packed {
      status_type        status;
      logic              sx;
      logic              sy;
      logic [PIX_W-1:0]  d;
      part_type          z;
      part_type          x;
      part_type          y;
   } div_type;

   // Four restoring division steps: one quotient bit per step.
   function automatic part_type div_step4(part_type p, logic [PIX_W-1:0] d);
      part_type       r;
      logic [REM_W:0] t;
      r = p;
      for (int i = 0; i < DIV_BPS; i++) begin
         t = {r.rem, r.dvd[PROD_W-1]};
         if (t >= {1'b0, d}) begin
            r.rem = REM_W'(t - {1'b0, d});
            r.dvd = {r.dvd[PROD_W-2:0], 1'b1};
         end else begin
            r.rem = t[REM_W-1:0];
            r.dvd = {r.dvd[PROD_W-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   // Signed 16-bit coefficient from a packed transform row.
   function automatic logic signed [15:0] coef(logic [63:0] row, logic [1:0] slot);
      return $signed(row[16*slot +: 16]);
   endfunction

endpackage

@@ rtl/drp_if.sv @@
// Pixel request channel.
interface drp_req_if import drp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_col;
   logic [PIX_W-1:0] pixel_row;
   logic [PIX_W-1:0] disparity;

   modport source (output valid, pixel_col, pixel_row, disparity, input ready);
   modport sink   (input valid, pixel_col, pixel_row, disparity, output ready);
endinterface

// Point response channel.
interface drp_rsp_if import drp_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              status;
   logic signed [PNT_W-1:0] point_x;
   logic signed [PNT_W-1:0] point_y;
   logic signed [PNT_W-1:0] point_z;

   modport source (output valid, status, point_x, point_y, point_z, input ready);
   modport sink   (input valid, status, point_x, point_y, point_z, output ready);
endinterface

@@ rtl/disparity_to_point_reprojection.sv @@
// Throughput: one pixel per cycle while the output is not stalled; 15 register
// stages, 8 of them a divider that resolves 4 quotient bits per stage for z,
// x and y in parallel. A stalled output holds the last stage and every full
// stage behind it up to the first bubble; bubbles upstream still close.
// Reset is synchronous: it clears all valid bits and loads the register
// reset values (identity transform, max depth 20 m).
module disparity_to_point_reprojection import drp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   drp_req_if.sink           req,
   drp_rsp_if.source         rsp,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam int NSTG  = 15;
   localparam int S_DIV = 2;
   localparam int S_SGN = S_DIV + DIV_STG + 1;
   localparam int S_MUL = S_SGN + 1;
   localparam int S_ACC = S_MUL + 1;
   localparam int S_OUT = S_ACC + 1;

   // Configuration registers.
   logic [CFG_W-1:0] focal_ff, base_ff, pu_ff, pv_ff, maxd_ff;
   logic [63:0]      row_ff [3];
   logic             wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff <= '0;
         base_ff  <= '0;
         pu_ff    <= '0;
         pv_ff    <= '0;
         maxd_ff  <= MAXD_RST;
         row_ff[0] <= ROW_X_RST;
         row_ff[1] <= ROW_Y_RST;
         row_ff[2] <= ROW_Z_RST;
      end else if (wr_en) begin
         case (paddr[5:3])
            REG_FOCAL: focal_ff  <= pwdata[CFG_W-1:0];
            REG_BASE:  base_ff   <= pwdata[CFG_W-1:0];
            REG_PU:    pu_ff     <= pwdata[CFG_W-1:0];
            REG_PV:    pv_ff     <= pwdata[CFG_W-1:0];
            REG_MAXD:  maxd_ff   <= pwdata[CFG_W-1:0];
            REG_ROW_X: row_ff[0] <= pwdata;
            REG_ROW_Y: row_ff[1] <= pwdata;
            REG_ROW_Z: row_ff[2] <= pwdata;
            default: ;
         endcase
      end
   end

   // Register read back.
   always_comb begin
      case (paddr[5:3])
         REG_FOCAL: prdata = DATA_W'(focal_ff);
         REG_BASE:  prdata = DATA_W'(base_ff);
         REG_PU:    prdata = DATA_W'(pu_ff);
         REG_PV:    prdata = DATA_W'(pv_ff);
         REG_MAXD:  prdata = DATA_W'(maxd_ff);
         REG_ROW_X: prdata = row_ff[0];
         REG_ROW_Y: prdata = row_ff[1];
         REG_ROW_Z: prdata = row_ff[2];
         default:   prdata = '0;
      endcase
   end

   // Stage enables: a stage loads when it is empty or its successor moves.
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] en;

   always_comb begin
      en[NSTG-1] = !vld_ff[NSTG-1] || rsp.ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign req.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req.valid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // Stage 0: input beat register.
   logic [PIX_W-1:0] u0_ff, v0_ff, d0_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         u0_ff <= req.pixel_col;
         v0_ff <= req.pixel_row;
         d0_ff <= req.disparity;
      end
   end

   // Stage 1: lateral offsets and the scaling products.
   logic signed [16:0] nx, ny;
   logic [CFG_W-1:0]   mx, my;
   logic [PROD_W-1:0]  fb1_ff, px1_ff, py1_ff;
   logic [MD_W-1:0]    md1_ff;
   logic [PIX_W-1:0]   d1_ff;
   logic               sx1_ff, sy1_ff;

   always_comb begin
      nx = $signed({1'b0, u0_ff, 4'b0}) - $signed({1'b0, pu_ff});
      ny = $signed({1'b0, v0_ff, 4'b0}) - $signed({1'b0, pv_ff});
      mx = nx[16] ? CFG_W'(-nx) : nx[CFG_W-1:0];
      my = ny[16] ? CFG_W'(-ny) : ny[CFG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         fb1_ff <= focal_ff * base_ff;
         px1_ff <= mx * base_ff;
         py1_ff <= my * base_ff;
         md1_ff <= maxd_ff * d0_ff;
         d1_ff  <= d0_ff;
         sx1_ff <= nx[16];
         sy1_ff <= ny[16];
      end
   end

   // Stage 2: depth range check, loads the divider.
   logic [CMP_W-1:0] fb10;
   logic             lo_ok, hi_ok;
   status_type       st2;
   div_type          div_ff [DIV_STG+1];

   always_comb begin
      fb10  = {1'b0, fb1_ff, 3'b0} + {3'b0, fb1_ff, 1'b0};
      lo_ok = fb10 > {8'b0, d1_ff, 16'b0};
      hi_ok = {4'b0, fb1_ff} < {md1_ff, 8'b0};
      if (d1_ff == '0) begin
         st2 = ST_NO_DISP;
      end else if (!lo_ok || !hi_ok) begin
         st2 = ST_RANGE;
      end else begin
         st2 = ST_VALID;
      end
   end

   always_ff @(posedge clock) begin
      if (en[S_DIV]) begin
         div_ff[0].status <= st2;
         div_ff[0].sx     <= sx1_ff;
         div_ff[0].sy     <= sy1_ff;
         div_ff[0].d      <= d1_ff;
         div_ff[0].z      <= '{rem: '0, dvd: fb1_ff};
         div_ff[0].x      <= '{rem: '0, dvd: px1_ff};
         div_ff[0].y      <= '{rem: '0, dvd: py1_ff};
      end
   end

   // Divider stages: four quotient bits each for all three divisions.
   for (genvar g = 1; g <= DIV_STG; g++) begin : g_div
      always_ff @(posedge clock) begin
         if (en[S_DIV+g]) begin
            div_ff[g].status <= div_ff[g-1].status;
            div_ff[g].sx     <= div_ff[g-1].sx;
            div_ff[g].sy     <= div_ff[g-1].sy;
            div_ff[g].d      <= div_ff[g-1].d;
            div_ff[g].z      <= div_step4(div_ff[g-1].z, div_ff[g-1].d);
            div_ff[g].x      <= div_step4(div_ff[g-1].x, div_ff[g-1].d);
            div_ff[g].y      <= div_step4(div_ff[g-1].y, div_ff[g-1].d);
         end
      end
   end

   // Sign stage: lateral quotients take the sign of their offset.
   logic signed [COORD_W-1:0] xyz_ff [3];
   status_type                st_sgn_ff;
   logic signed [COORD_W-1:0] qx, qy;

   always_comb begin
      qx = $signed({2'b0, div_ff[DIV_STG].x.dvd});
      qy = $signed({2'b0, div_ff[DIV_STG].y.dvd});
   end

   always_ff @(posedge clock) begin
      if (en[S_SGN]) begin
         xyz_ff[0] <= div_ff[DIV_STG].sx ? -qx : qx;
         xyz_ff[1] <= div_ff[DIV_STG].sy ? -qy : qy;
         xyz_ff[2] <= $signed({2'b0, div_ff[DIV_STG].z.dvd});
         st_sgn_ff <= div_ff[DIV_STG].status;
      end
   end

   // Multiply stage: nine rotation products.
   logic signed [MUL_W-1:0] prod_ff [3][3];
   status_type              st_mul_ff;

   always_ff @(posedge clock) begin
      if (en[S_MUL]) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= MUL_W'(coef(row_ff[r], 2'(c)) * xyz_ff[c]);
            end
         end
         st_mul_ff <= st_sgn_ff;
      end
   end

   // Accumulate stage: products plus translation in Q30, with rounding bias.
   logic signed [ACC_W-1:0] acc_ff [3];
   status_type              st_acc_ff;

   always_ff @(posedge clock) begin
      if (en[S_ACC]) begin
         for (int r = 0; r < 3; r++) begin
            acc_ff[r] <= ACC_W'(prod_ff[r][0]) + ACC_W'(prod_ff[r][1])
                       + ACC_W'(prod_ff[r][2])
                       + (ACC_W'(coef(row_ff[r], 2'd3)) <<< 22) + RND_BIAS;
         end
         st_acc_ff <= st_mul_ff;
      end
   end

   // Output stage: floor to Q16, saturate, zero the point on a bad status.
   logic signed [ACC_W-15:0] shr [3];
   logic signed [PNT_W-1:0]  sat [3];
   logic signed [PNT_W-1:0]  pnt_ff [3];
   status_type               st_out_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         shr[r] = acc_ff[r][ACC_W-1:14];
         if (shr[r] > (ACC_W-14)'(PNT_MAX)) begin
            sat[r] = PNT_MAX;
         end else if (shr[r] < (ACC_W-14)'(PNT_MIN)) begin
            sat[r] = PNT_MIN;
         end else begin
            sat[r] = shr[r][PNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[S_OUT]) begin
         for (int r = 0; r < 3; r++) begin
            pnt_ff[r] <= (st_acc_ff == ST_VALID) ? sat[r] : '0;
         end
         st_out_ff <= st_acc_ff;
      end
   end

   assign rsp.valid   = vld_ff[S_OUT];
   assign rsp.status  = st_out_ff;
   assign rsp.point_x = pnt_ff[0];
   assign rsp.point_y = pnt_ff[1];
   assign rsp.point_z = pnt_ff[2];

endmodule

@@ rtl/drp_check.sv @@
module drp_check import drp_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [1:0]              rsp_status,
   input logic signed [PNT_W-1:0] rsp_point_x,
   input logic signed [PNT_W-1:0] rsp_point_y,
   input logic signed [PNT_W-1:0] rsp_point_z
);

   // A stalled result beat keeps its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_point_x) && $stable(rsp_point_y) && $stable(rsp_point_z))
      else $error("stalled result beat changed");

   // A pixel without a valid point carries a zero point.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_VALID |->
         rsp_point_x == '0 && rsp_point_y == '0 && rsp_point_z == '0)
      else $error("rejected pixel carries a nonzero point");

   // Reset empties the pipeline.
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // With an empty output stage nothing blocks the input.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while output stage is empty");

endmodule

bind disparity_to_point_reprojection drp_check u_drp_check (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_status  (rsp.status),
   .rsp_point_x (rsp.point_x),
   .rsp_point_y (rsp.point_y),
   .rsp_point_z (rsp.point_z)
);

@@ verif/drp_scoreboard.sv @@
import drp_pkg::*;

// Point predictor and store of expected points for the reprojection block.
class drp_point_board;

   typedef struct {
      status_type      status;
      logic [31:0]     px;
      logic [31:0]     py;
      logic [31:0]     pz;
   } point_type;

   // Register copy, held as plain integers so that products stay in 64 bits.
   longint      focal;
   longint      base;
   longint      cu;
   longint      cv;
   longint      maxd;
   logic [63:0] row_x;
   logic [63:0] row_y;
   logic [63:0] row_z;

   point_type   expected_points[$];
   int          errors;

   function new();
      focal  = 0;
      base   = 0;
      cu     = 0;
      cv     = 0;
      maxd   = MAXD_RST;
      row_x  = ROW_X_RST;
      row_y  = ROW_Y_RST;
      row_z  = ROW_Z_RST;
      errors = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [63:0] value);
      case (idx)
         REG_FOCAL: focal = value[15:0];
         REG_BASE:  base  = value[15:0];
         REG_PU:    cu    = value[15:0];
         REG_PV:    cv    = value[15:0];
         REG_MAXD:  maxd  = value[15:0];
         REG_ROW_X: row_x = value;
         REG_ROW_Y: row_y = value;
         REG_ROW_Z: row_z = value;
         default: ;
      endcase
   endfunction

   // Lateral offset times baseline over disparity, truncated toward zero.
   function longint lateral(longint num, longint disp);
      longint q;
      q = ((num < 0 ? -num : num) * base) / disp;
      return (num < 0) ? -q : q;
   endfunction

   // One transform row: Q30 sum, round half up to Q16, saturate to 32 bits.
   function logic [31:0] transform(logic [63:0] row, longint x, longint y, longint z);
      longint acc;
      acc = longint'($signed(row[15:0])) * x + longint'($signed(row[31:16])) * y
          + longint'($signed(row[47:32])) * z
          + longint'($signed(row[63:48])) * 64'sd4194304 + 64'sd8192;
      acc = acc >>> 14;
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      return acc[31:0];
   endfunction

   function void note_pixel(logic [11:0] col, logic [11:0] row, logic [11:0] disp);
      point_type e;
      longint fb;
      longint d;
      longint x;
      longint y;
      longint z;
      e = '{ST_VALID, 32'd0, 32'd0, 32'd0};
      d = disp;
      fb = focal * base;
      if (disp == 0) begin
         e.status = ST_NO_DISP;
      end else if (!(10 * fb > 65536 * d) || !(fb < maxd * 256 * d)) begin
         e.status = ST_RANGE;
      end else begin
         z = fb / d;
         x = lateral(longint'(col) * 16 - cu, d);
         y = lateral(longint'(row) * 16 - cv, d);
         e.px = transform(row_x, x, y, z);
         e.py = transform(row_y, x, y, z);
         e.pz = transform(row_z, x, y, z);
      end
      expected_points = {expected_points, e};
   endfunction

   function void check_point(logic [1:0] status, logic [31:0] px, logic [31:0] py,
                             logic [31:0] pz);
      point_type e;
      if (expected_points.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("unexpected point beat: status %0d x %h y %h z %h", status, px, py, pz);
         return;
      end
      e = expected_points.pop_front();
      if (status !== e.status || px !== e.px || py !== e.py || pz !== e.pz) begin
         errors++;
         if (errors <= 10)
            $display("point mismatch: expected status %0d x %h y %h z %h, got %0d %h %h %h",
                     e.status, e.px, e.py, e.pz, status, px, py, pz);
      end
   endfunction

   function int pending();
      return expected_points.size();
   endfunction
endclass

@@ verif/tb_top.sv @@
module tb_top;
   import drp_pkg::*;

   localparam int CYCLE_LIMIT = 300000;

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   int send_pct;
   int recv_pct;
   int hold_cycles;
   int cycle_count;

   drp_point_board board;

   drp_req_if req_if();
   drp_rsp_if rsp_if();

   disparity_to_point_reprojection u_top (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Receiver: random stalls, or a long hold-off while hold_cycles counts down.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_pct);
         end
      end
   end

   // Every point beat is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         board.check_point(rsp_if.status, rsp_if.point_x, rsp_if.point_y, rsp_if.point_z);
   end

   // Run time limit.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** disparity_to_point_reprojection: FAILED **");
      $finish;
   end

   // Register write: setup cycle, then access cycle; the caller ends the transfer.
   task automatic csr_write(logic [2:0] idx, logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      board.write_reg(idx, value);
      @(negedge clock);
   endtask

   // Waits for the pipeline to drain, then loads all registers.
   task automatic load_setup(logic [15:0] f, logic [15:0] b, logic [15:0] pu,
                             logic [15:0] pv, logic [15:0] md,
                             logic [63:0] rx, logic [63:0] ry, logic [63:0] rz);
      while (board.pending() != 0) @(negedge clock);
      csr_write(REG_FOCAL, {48'd0, f});
      csr_write(REG_BASE, {48'd0, b});
      csr_write(REG_PU, {48'd0, pu});
      csr_write(REG_PV, {48'd0, pv});
      csr_write(REG_MAXD, {48'd0, md});
      csr_write(REG_ROW_X, rx);
      csr_write(REG_ROW_Y, ry);
      csr_write(REG_ROW_Z, rz);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // One pixel beat; called at a falling edge, returns at a falling edge.
   task automatic send_pixel(logic [11:0] col, logic [11:0] row, logic [11:0] disp);
      while ($urandom_range(99) < send_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.pixel_col <= col;
      req_if.pixel_row <= row;
      req_if.disparity <= disp;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      board.note_pixel(col, row, disp);
      @(negedge clock);
   endtask

   // Random pixels: mostly real disparities, a few missing ones.
   task automatic send_random(int count);
      logic [11:0] disp;
      for (int i = 0; i < count; i++) begin
         disp = ($urandom_range(19) == 0) ? 12'd0 : 12'($urandom_range(4095, 1));
         send_pixel(12'($urandom), 12'($urandom), disp);
      end
      req_if.valid <= 1'b0;
   endtask

   function automatic logic [63:0] random_row();
      return {$urandom, $urandom};
   endfunction

   // Small rotation terms and translation, so that most points stay unsaturated.
   function automatic logic [63:0] mild_row();
      logic [63:0] r;
      r = {16'($signed($urandom_range(2047)) - 16'sd1024),
           16'($signed($urandom_range(32767)) - 16'sd16384),
           16'($signed($urandom_range(32767)) - 16'sd16384),
           16'($signed($urandom_range(32767)) - 16'sd16384)};
      return r;
   endfunction

   initial begin
      board = new();
      send_pct    = 0;
      recv_pct    = 0;
      hold_cycles = 0;
      reset       = 1'b1;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      req_if.valid     = 1'b0;
      req_if.pixel_col = '0;
      req_if.pixel_row = '0;
      req_if.disparity = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset setup: zero focal length, so every real disparity is out of range.
      send_pixel(12'd100, 12'd200, 12'd0);
      send_pixel(12'd4095, 12'd4095, 12'd4095);
      send_pixel(12'd0, 12'd0, 12'd1);
      req_if.valid <= 1'b0;

      // Depth of exactly 16 m sits on the upper limit; 0.1 m at disparity 2560.
      load_setup(16'd4096, 16'd4096, 16'h8000, 16'h8000, 16'd4096,
                 ROW_X_RST, ROW_Y_RST, ROW_Z_RST);
      send_pixel(12'd10, 12'd20, 12'd16);
      send_pixel(12'd10, 12'd20, 12'd17);
      send_pixel(12'd4095, 12'd0, 12'd2559);
      send_pixel(12'd4095, 12'd0, 12'd2560);
      send_pixel(12'd0, 12'd4095, 12'd4095);
      send_pixel(12'd2048, 12'd2048, 12'd100);
      send_pixel(12'd0, 12'd0, 12'd0);
      req_if.valid <= 1'b0;

      // All registers at their top values: saturating points.
      load_setup(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 64'h7FFF_8000_7FFF_8000, 64'h8000_7FFF_8000_7FFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_pixel(12'd0, 12'd0, 12'd1);
      send_pixel(12'd4095, 12'd4095, 12'd1);
      send_pixel(12'd4095, 12'd0, 12'd4095);
      send_pixel(12'd0, 12'd4095, 12'd200);
      send_pixel(12'd1234, 12'd567, 12'd0);
      req_if.valid <= 1'b0;

      // Random part over three idle patterns, several setups in each.
      for (int seg = 0; seg < 3; seg++) begin
         send_pct = (seg == 0) ? 11 : (seg == 1) ? 56 : 0;
         recv_pct = (seg == 0) ? 56 : (seg == 1) ? 11 : 0;

         load_setup(16'd8000, 16'd16384, 16'($urandom_range(65535)),
                    16'($urandom_range(65535)), 16'hFFFF, mild_row(), mild_row(), mild_row());
         if (seg == 0) hold_cycles = 80;
         send_random(110);

         load_setup(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), random_row(), random_row(), random_row());
         send_random(50);

         load_setup(16'($urandom_range(20000, 2000)), 16'($urandom_range(40000, 4000)),
                    16'($urandom_range(65535)), 16'($urandom_range(65535)),
                    16'($urandom_range(65535, 1024)), mild_row(), mild_row(), mild_row());
         send_random(50);
      end

      // Zero depth limit: nothing can be in range.
      load_setup(16'd8000, 16'd16384, 16'd0, 16'd0, 16'd0,
                 ROW_X_RST, ROW_Y_RST, ROW_Z_RST);
      send_random(10);

      while (board.pending() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      if (board.errors == 0)
         $display("** disparity_to_point_reprojection: PASSED **");
      else
         $display("** disparity_to_point_reprojection: FAILED **");
      $finish;
   end
endmodule

@@ sim.f @@
rtl/drp_pkg.sv
rtl/drp_if.sv
rtl/disparity_to_point_reprojection.sv
rtl/drp_check.sv
verif/drp_scoreboard.sv
verif/tb_top.sv
